/* sv/svf_pkg.sv */
package svf_pkg;

    // fixed point format
    localparam int FRAC_BITS = 15;

    // field widths
    localparam int SAMPLE_W = 18;
    localparam int COEFF_W  = 17;
    localparam int MODE_W   = 2;
    localparam int DAMP_W   = 20;
    localparam int OUT_W    = 24;
    localparam int ACC_W    = 32;

    // configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = DAMP_W;

    localparam logic [CFG_IDX_W-1:0] REG_FILTER_MODE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DAMPING     = 1'd1;

    localparam logic [DAMP_W-1:0] DAMP_MAX   = 20'd655360;
    localparam logic [DAMP_W-1:0] DAMP_RESET = 20'd32768;

    // output select codes
    localparam logic [MODE_W-1:0] MODE_LOW  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_BAND = 2'd1;
    localparam logic [MODE_W-1:0] MODE_HIGH = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_RND,
        ST_ADD,
        ST_DONE
    } svf_state_t;

    // which product the shared multiplier is working on
    typedef enum logic [1:0] {
        PH_DAMP,
        PH_BAND,
        PH_LOW
    } svf_phase_t;

endpackage

/* sv/svf_if.sv */
interface svf_in_if;
    import svf_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample;
    logic [COEFF_W-1:0]         tune_coeff;
    logic                       restart;

    modport source (output valid, output sample, output tune_coeff, output restart,
                    input ready);
    modport sink   (input valid, input sample, input tune_coeff, input restart,
                    output ready);
endinterface

interface svf_out_if;
    import svf_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [OUT_W-1:0] filtered;
    logic                    range_error;

    modport source (output valid, output filtered, output range_error, input ready);
    modport sink   (input valid, input filtered, input range_error, output ready);
endinterface

/* sv/state_variable_filter_core.sv */
// Chamberlin state variable filter with a bit-serial datapath. Each sample beat
// runs the three products Q*band, F*high and F*band one after another through a
// single shift-add multiplier that retires one coefficient bit per cycle. For an
// in-range sample, each product steps through all 20 multiplier bits (the
// damping width), then a rounding and an accumulate/saturate state, and the
// result beat follows the last product. A sample with magnitude above 1.0 is
// rejected with range_error set and filtered 0, and the integrators are left
// untouched. One sample is in flight at a time; a new sample is taken as soon
// as the previous result sits in the output register, even if the sink has
// not yet taken it. Configuration writes take effect on the next sample and
// must only be issued while the filter is idle; a damping write above 20.0 is
// dropped.
module state_variable_filter_core (
    input  logic                          clk,
    input  logic                          rst_n,
    svf_in_if.sink                        sample_ch,
    svf_out_if.source                     result_ch,
    input  logic                          cfg_we,
    input  logic [svf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [svf_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import svf_pkg::*;

    // multiplier and adder widths
    localparam int MUL_W    = DAMP_W;             // coefficient bits, one per cycle
    localparam int ACC_HI_W = ACC_W + 2;          // running partial sum
    localparam int PROD_W   = ACC_HI_W + MUL_W;   // full product
    localparam int RND_W    = PROD_W - FRAC_BITS; // rounded product
    localparam int SUM_W    = RND_W + 2;          // accumulate headroom
    localparam int CNT_W    = $clog2(MUL_W);

    localparam logic signed [SAMPLE_W-1:0] SAMPLE_ONE = SAMPLE_W'(1) <<< FRAC_BITS;
    localparam logic [CNT_W-1:0]           CNT_LAST   = CNT_W'(MUL_W - 1);

    // saturate the accumulate result to the integrator width
    function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [SUM_W-1:0] v);
        logic [SUM_W-ACC_W:0] top;
        top = v[SUM_W-1:ACC_W-1];
        if ((&top) || !(|top))
            return v[ACC_W-1:0];
        else if (v[SUM_W-1])
            return {1'b1, {(ACC_W-1){1'b0}}};
        else
            return {1'b0, {(ACC_W-1){1'b1}}};
    endfunction

    // saturate an integrator value to the output width
    function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [ACC_W-1:0] v);
        logic [ACC_W-OUT_W:0] top;
        top = v[ACC_W-1:OUT_W-1];
        if ((&top) || !(|top))
            return v[OUT_W-1:0];
        else if (v[ACC_W-1])
            return {1'b1, {(OUT_W-1){1'b0}}};
        else
            return {1'b0, {(OUT_W-1){1'b1}}};
    endfunction

    // control state
    svf_state_t                state_reg, state_next;
    svf_phase_t                phase_reg, phase_next;
    logic [CNT_W-1:0]          bit_cnt_reg, bit_cnt_next;
    logic                      out_valid_reg, out_valid_next;
    logic [MODE_W-1:0]         mode_reg, mode_next;
    logic [DAMP_W-1:0]         damp_reg, damp_next;

    // filter state
    logic signed [ACC_W-1:0]   low_reg, low_next;
    logic signed [ACC_W-1:0]   band_reg, band_next;

    // per-sample payload
    logic signed [SAMPLE_W-1:0] x_reg, x_next;
    logic [COEFF_W-1:0]         f_reg, f_next;
    logic                       err_reg, err_next;
    logic signed [ACC_W-1:0]    hi_reg, hi_next;
    logic [MUL_W-1:0]           mult_reg, mult_next;
    logic signed [ACC_HI_W-1:0] acc_hi_reg, acc_hi_next;
    logic [MUL_W-1:0]           acc_lo_reg, acc_lo_next;
    logic signed [RND_W-1:0]    rnd_reg, rnd_next;
    logic signed [OUT_W-1:0]    out_filtered_reg, out_filtered_next;
    logic                       out_err_reg, out_err_next;

    // handshake and datapath nets
    logic                       in_beat;
    logic                       in_bad;
    logic                       out_load;
    logic signed [ACC_W-1:0]    mcand;
    logic signed [ACC_HI_W-1:0] addend;
    logic signed [ACC_HI_W-1:0] acc_sum;
    logic [PROD_W-1:0]          prod;
    logic signed [SUM_W-1:0]    rnd_ext;
    logic signed [SUM_W-1:0]    sum;
    logic signed [ACC_W-1:0]    sum_sat;
    logic signed [ACC_W-1:0]    sel;

    assign sample_ch.ready      = (state_reg == ST_IDLE);
    assign result_ch.valid      = out_valid_reg;
    assign result_ch.filtered   = out_filtered_reg;
    assign result_ch.range_error = out_err_reg;

    assign in_beat  = sample_ch.valid && sample_ch.ready;
    assign in_bad   = (sample_ch.sample > SAMPLE_ONE) || (sample_ch.sample < -SAMPLE_ONE);
    // result register frees up when empty or when the sink takes its beat
    assign out_load = (state_reg == ST_DONE) && (!out_valid_reg || result_ch.ready);

    // multiplicand: old band for the damping term, high, then the new band
    assign mcand   = (phase_reg == PH_BAND) ? hi_reg : band_reg;
    // shift-add step: add multiplicand on a set coefficient bit, then shift right
    assign addend  = mult_reg[0] ? {{(ACC_HI_W-ACC_W){mcand[ACC_W-1]}}, mcand}
                                 : '0;
    assign acc_sum = acc_hi_reg + addend;

    // round half up: floor shift plus the first dropped bit
    assign prod    = {acc_hi_reg, acc_lo_reg};
    assign rnd_ext = {{(SUM_W-RND_W){rnd_reg[RND_W-1]}}, rnd_reg};

    always_comb
    begin
        unique case (phase_reg)
            PH_DAMP:
            begin
                sum = {{(SUM_W-SAMPLE_W){x_reg[SAMPLE_W-1]}}, x_reg}
                    - {{(SUM_W-ACC_W){low_reg[ACC_W-1]}}, low_reg}
                    - rnd_ext;
            end
            PH_BAND:
            begin
                sum = {{(SUM_W-ACC_W){band_reg[ACC_W-1]}}, band_reg} + rnd_ext;
            end
            default:
            begin
                sum = {{(SUM_W-ACC_W){low_reg[ACC_W-1]}}, low_reg} + rnd_ext;
            end
        endcase
    end

    assign sum_sat = sat_acc(sum);

    // output select; the unused mode falls back to low-pass
    always_comb
    begin
        unique case (mode_reg)
            MODE_HIGH: sel = hi_reg;
            MODE_BAND: sel = band_reg;
            default:   sel = low_reg;
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_beat)
                    state_next = in_bad ? ST_DONE : ST_MUL;
            end
            ST_MUL:
            begin
                if (bit_cnt_reg == CNT_LAST)
                    state_next = ST_RND;
            end
            ST_RND:
            begin
                state_next = ST_ADD;
            end
            ST_ADD:
            begin
                state_next = (phase_reg == PH_LOW) ? ST_DONE : ST_MUL;
            end
            ST_DONE:
            begin
                if (out_load)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        phase_next        = phase_reg;
        bit_cnt_next      = bit_cnt_reg;
        low_next          = low_reg;
        band_next         = band_reg;
        x_next            = x_reg;
        f_next            = f_reg;
        err_next          = err_reg;
        hi_next           = hi_reg;
        mult_next         = mult_reg;
        acc_hi_next       = acc_hi_reg;
        acc_lo_next       = acc_lo_reg;
        rnd_next          = rnd_reg;
        out_valid_next    = out_valid_reg && !result_ch.ready;
        out_filtered_next = out_filtered_reg;
        out_err_next      = out_err_reg;
        mode_next         = mode_reg;
        damp_next         = damp_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_beat)
                begin
                    err_next     = in_bad;
                    x_next       = sample_ch.sample;
                    f_next       = sample_ch.tune_coeff;
                    phase_next   = PH_DAMP;
                    bit_cnt_next = '0;
                    mult_next    = damp_reg;
                    acc_hi_next  = '0;
                    acc_lo_next  = '0;
                    if (!in_bad && sample_ch.restart)
                    begin
                        low_next  = '0;
                        band_next = '0;
                    end
                end
            end
            ST_MUL:
            begin
                acc_hi_next  = acc_sum >>> 1;
                acc_lo_next  = {acc_sum[0], acc_lo_reg[MUL_W-1:1]};
                mult_next    = mult_reg >> 1;
                bit_cnt_next = bit_cnt_reg + CNT_W'(1);
            end
            ST_RND:
            begin
                rnd_next = prod[PROD_W-1:FRAC_BITS]
                         + {{(RND_W-1){1'b0}}, prod[FRAC_BITS-1]};
            end
            ST_ADD:
            begin
                unique case (phase_reg)
                    PH_DAMP: hi_next   = sum_sat;
                    PH_BAND: band_next = sum_sat;
                    default: low_next  = sum_sat;
                endcase
                // next product always uses the tuning coefficient
                bit_cnt_next = '0;
                mult_next    = {{(MUL_W-COEFF_W){1'b0}}, f_reg};
                acc_hi_next  = '0;
                acc_lo_next  = '0;
                phase_next   = (phase_reg == PH_DAMP) ? PH_BAND : PH_LOW;
            end
            ST_DONE:
            begin
                if (out_load)
                begin
                    out_valid_next    = 1'b1;
                    out_err_next      = err_reg;
                    out_filtered_next = err_reg ? '0 : sat_out(sel);
                end
            end
            default:
            begin
            end
        endcase

        // register writes
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_FILTER_MODE: mode_next = cfg_wdata[MODE_W-1:0];
                REG_DAMPING:
                begin
                    if (cfg_wdata <= DAMP_MAX)
                        damp_next = cfg_wdata;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            phase_reg     <= PH_DAMP;
            bit_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
            mode_reg      <= MODE_LOW;
            damp_reg      <= DAMP_RESET;
            low_reg       <= '0;
            band_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            bit_cnt_reg   <= bit_cnt_next;
            out_valid_reg <= out_valid_next;
            mode_reg      <= mode_next;
            damp_reg      <= damp_next;
            low_reg       <= low_next;
            band_reg      <= band_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg            <= x_next;
        f_reg            <= f_next;
        err_reg          <= err_next;
        hi_reg           <= hi_next;
        mult_reg         <= mult_next;
        acc_hi_reg       <= acc_hi_next;
        acc_lo_reg       <= acc_lo_next;
        rnd_reg          <= rnd_next;
        out_filtered_reg <= out_filtered_next;
        out_err_reg      <= out_err_next;
    end

endmodule

/* sv/svf_core_chk.sv */
module svf_core_chk (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            in_valid,
    input logic                            in_ready,
    input logic                            out_valid,
    input logic                            out_ready,
    input logic signed [svf_pkg::OUT_W-1:0] filtered,
    input logic                            range_error
);
    import svf_pkg::*;

    // samples accepted but not yet delivered
    logic [1:0] pend_reg;
    logic [1:0] pend_next;

    always_comb
    begin
        pend_next = pend_reg;
        if ((in_valid && in_ready) && !(out_valid && out_ready))
            pend_next = pend_reg + 2'd1;
        else if (!(in_valid && in_ready) && (out_valid && out_ready))
            pend_next = pend_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pend_reg <= 2'd0;
        else
            pend_reg <= pend_next;
    end

    // at most one sample in the datapath and one in the result register
    a_accept_room: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |-> (pend_reg <= 2'd1))
        else $error("sample accepted with no room");

    // no result beat without a sample behind it
    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (pend_reg != 2'd0))
        else $error("result beat without a pending sample");

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=>
            (out_valid && $stable(filtered) && $stable(range_error)))
        else $error("stalled result beat changed");

    // rejected sample reports zero
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && range_error) |-> (filtered == '0))
        else $error("range error with nonzero output");

endmodule

bind state_variable_filter_core svf_core_chk u_svf_core_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (sample_ch.valid),
    .in_ready    (sample_ch.ready),
    .out_valid   (result_ch.valid),
    .out_ready   (result_ch.ready),
    .filtered    (result_ch.filtered),
    .range_error (result_ch.range_error)
);

/* tb/sv/testbench.sv */
module testbench;
    import svf_pkg::*;

    // fixed point bounds used by the predictor
    localparam int     UNITY    = 1 << FRAC_BITS;
    localparam longint HALF_LSB = longint'(1) << (FRAC_BITS - 1);
    localparam longint ACC_MAX  = (longint'(1) << (ACC_W - 1)) - 1;
    localparam longint ACC_MIN  = -(longint'(1) << (ACC_W - 1));
    localparam longint OUT_MAX  = (longint'(1) << (OUT_W - 1)) - 1;
    localparam longint OUT_MIN  = -(longint'(1) << (OUT_W - 1));

    // the spare select code, which falls back to low-pass
    localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

    // acceptance to result beat for an in-range sample
    localparam int RESULT_LATENCY = 68;
    localparam int MAX_WAIT       = 13;
    localparam int PHASES         = 8;
    localparam int PHASE_BEATS    = 150;
    localparam int HOLD_CYCLES    = 500;
    localparam int N_ROWS         = 29;

    typedef struct {
        logic signed [OUT_W-1:0] filtered;
        logic                    range_error;
    } svf_result_t;

    typedef enum logic [1:0] {
        ROW_WRITE,
        ROW_BEAT,
        ROW_CHECKED
    } row_kind_t;

    // one line of the directed table; want_* only counts on checked rows
    typedef struct {
        row_kind_t                  kind;
        logic [CFG_IDX_W-1:0]       reg_idx;
        logic [CFG_DATA_W-1:0]      reg_val;
        logic signed [SAMPLE_W-1:0] smp;
        logic [COEFF_W-1:0]         coef;
        logic                       rst;
        logic signed [OUT_W-1:0]    want_filt;
        logic                       want_err;
    } stim_row_t;

    logic clk;
    logic rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    svf_in_if  in_ch ();
    svf_out_if out_ch ();

    state_variable_filter_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample_ch (in_ch),
        .result_ch (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // predictor copy of the registers and the two integrators
    logic [MODE_W-1:0] mode_reg;
    logic [DAMP_W-1:0] damp_reg;
    int                low_acc;
    int                band_acc;

    // outputs still owed by the filter, oldest first
    svf_result_t due_outputs[$];
    svf_result_t seen_want;

    // pacing knobs, changed per setting phase
    bit          tx_busy;
    bit          rx_busy;
    bit          rx_hold;
    int unsigned rx_left;
    int          phase_no = -1;

    // bookkeeping for the closing summary
    int fails;
    int n_beats;
    int n_rejected;
    int n_clipped;
    int n_writes;

    // directed table: range edges, every select code, damping edges,
    // a dropped damping write and the oversized coefficient
    stim_row_t directed_rows [N_ROWS] = '{
        // fresh state, zero in, zero out
        '{ROW_CHECKED, REG_FILTER_MODE, 20'd0, 18'sd0, 17'd0, 1'b0, 24'sd0, 1'b0},
        // just outside +/-1.0 and the field extremes are rejected, restart ignored
        '{ROW_CHECKED, REG_FILTER_MODE, 20'd0, 18'sd32769, 17'd1000, 1'b1, 24'sd0, 1'b1},
        '{ROW_CHECKED, REG_FILTER_MODE, 20'd0, -18'sd32769, 17'd1000, 1'b0, 24'sd0, 1'b1},
        '{ROW_CHECKED, REG_FILTER_MODE, 20'd0, 18'sd131071, 17'd65536, 1'b0, 24'sd0, 1'b1},
        '{ROW_CHECKED, REG_FILTER_MODE, 20'd0, 18'h20000, 17'd131071, 1'b1, 24'sd0, 1'b1},
        // exactly +/-1.0 is accepted, nominal and oversized coefficient, then a zero coefficient
        '{ROW_BEAT, REG_FILTER_MODE, 20'd0, 18'sd32768, 17'd65536, 1'b0, 24'sd0, 1'b0},
        '{ROW_BEAT, REG_FILTER_MODE, 20'd0, -18'sd32768, 17'd131071, 1'b0, 24'sd0, 1'b0},
        '{ROW_BEAT, REG_FILTER_MODE, 20'd0, 18'sd12345, 17'd0, 1'b0, 24'sd0, 1'b0},
        // high-pass right after a restart is the sample itself
        '{ROW_WRITE, REG_FILTER_MODE, {18'd0, MODE_HIGH}, 18'sd0, 17'd0, 1'b0, 24'sd0, 1'b0},
        '{ROW_CHECKED, REG_FILTER_MODE, 20'd0, 18'sd32768, 17'd65536, 1'b1, 24'sd32768, 1'b0},
        '{ROW_CHECKED, REG_FILTER_MODE, 20'd0, -18'sd32768, 17'd131071, 1'b1,
          -24'sd32768, 1'b0},
        '{ROW_BEAT, REG_FILTER_MODE, 20'd0, -18'sd32768, 17'd131071, 1'b0, 24'sd0, 1'b0},
        // no damping at all, state runs away
        '{ROW_WRITE, REG_DAMPING, 20'd0, 18'sd0, 17'd0, 1'b0, 24'sd0, 1'b0},
        '{ROW_BEAT, REG_FILTER_MODE, 20'd0, 18'sd32768, 17'd131071, 1'b0, 24'sd0, 1'b0},
        '{ROW_BEAT, REG_FILTER_MODE, 20'd0, 18'sd32768, 17'd131071, 1'b0, 24'sd0, 1'b0},
        // heaviest legal damping
        '{ROW_WRITE, REG_DAMPING, DAMP_MAX, 18'sd0, 17'd0, 1'b0, 24'sd0, 1'b0},
        '{ROW_BEAT, REG_FILTER_MODE, 20'd0, -18'sd32768, 17'd65536, 1'b0, 24'sd0, 1'b0},
        '{ROW_BEAT, REG_FILTER_MODE, 20'd0, 18'sd20000, 17'd40000, 1'b0, 24'sd0, 1'b0},
        // over the damping limit, the write is dropped
        '{ROW_WRITE, REG_DAMPING, 20'hFFFFF, 18'sd0, 17'd0, 1'b0, 24'sd0, 1'b0},
        '{ROW_BEAT, REG_FILTER_MODE, 20'd0, 18'sd1, 17'd1, 1'b0, 24'sd0, 1'b0},
        '{ROW_BEAT, REG_FILTER_MODE, 20'd0, -18'sd1, 17'd99999, 1'b0, 24'sd0, 1'b0},
        // band-pass with a zero coefficient after restart stays at zero
        '{ROW_WRITE, REG_FILTER_MODE, {18'd0, MODE_BAND}, 18'sd0, 17'd0, 1'b0, 24'sd0, 1'b0},
        '{ROW_CHECKED, REG_FILTER_MODE, 20'd0, 18'sd32768, 17'd0, 1'b1, 24'sd0, 1'b0},
        '{ROW_BEAT, REG_FILTER_MODE, 20'd0, -18'sd1, 17'd65536, 1'b0, 24'sd0, 1'b0},
        // spare select code
        '{ROW_WRITE, REG_FILTER_MODE, {18'd0, MODE_SPARE}, 18'sd0, 17'd0, 1'b0, 24'sd0, 1'b0},
        '{ROW_BEAT, REG_FILTER_MODE, 20'd0, 18'sd32768, 17'd65536, 1'b0, 24'sd0, 1'b0},
        '{ROW_CHECKED, REG_FILTER_MODE, 20'd0, 18'sd0, 17'd0, 1'b1, 24'sd0, 1'b0},
        // back to the reset settings
        '{ROW_WRITE, REG_FILTER_MODE, {18'd0, MODE_LOW}, 18'sd0, 17'd0, 1'b0, 24'sd0, 1'b0},
        '{ROW_WRITE, REG_DAMPING, DAMP_RESET, 18'sd0, 17'd0, 1'b0, 24'sd0, 1'b0}
    };

    function automatic longint round_q(input longint p);
        // round half up, then drop the fraction bits of the product
        return (p + HALF_LSB) >>> FRAC_BITS;
    endfunction

    function automatic longint clip(input longint v, input longint lo, input longint hi);
        if (v < lo)
            return lo;
        if (v > hi)
            return hi;
        return v;
    endfunction

    // one filter step on the predictor state
    function automatic svf_result_t filter_sample(input logic signed [SAMPLE_W-1:0] smp,
                                                  input logic [COEFF_W-1:0] coef,
                                                  input logic rst);
        svf_result_t res;
        longint      x;
        longint      f;
        longint      hp;
        longint      bp;
        longint      lp;
        longint      sel;
        x = longint'(smp);
        f = longint'(coef);
        res.filtered    = '0;
        res.range_error = 1'b1;
        // out of range: flag it, integrators and restart untouched
        if (x > UNITY || x < -UNITY)
            return res;
        if (rst)
        begin
            low_acc  = 0;
            band_acc = 0;
        end
        hp = clip(x - low_acc - round_q(longint'(damp_reg) * band_acc), ACC_MIN, ACC_MAX);
        bp = clip(band_acc + round_q(f * hp), ACC_MIN, ACC_MAX);
        lp = clip(low_acc + round_q(f * bp), ACC_MIN, ACC_MAX);
        band_acc = int'(bp);
        low_acc  = int'(lp);
        case (mode_reg)
            MODE_HIGH: sel = hp;
            MODE_BAND: sel = bp;
            default:   sel = lp;
        endcase
        sel = clip(sel, OUT_MIN, OUT_MAX);
        res.filtered    = sel[OUT_W-1:0];
        res.range_error = 1'b0;
        return res;
    endfunction

    // nominal, tiny, oversized or fully random tuning coefficient
    function automatic logic [COEFF_W-1:0] draw_coeff();
        case ($urandom_range(0, 9))
            0, 1:    return COEFF_W'($urandom_range(0, 2000));
            2:       return COEFF_W'($urandom_range(2 * UNITY + 1, (1 << COEFF_W) - 1));
            3:       return COEFF_W'($urandom());
            default: return COEFF_W'($urandom_range(0, 2 * UNITY));
        endcase
    endfunction

    // offer one sample beat, after a random gap when tx_busy is set, then queue what it should give
    task automatic send_sample(input logic signed [SAMPLE_W-1:0] smp,
                               input logic [COEFF_W-1:0] coef, input logic rst,
                               input bit typed, input logic signed [OUT_W-1:0] want_filt,
                               input logic want_err);
        int unsigned gap;
        svf_result_t res;
        gap = tx_busy ? $urandom_range(0, MAX_WAIT) : 0;
        if (gap != 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.sample     <= smp;
        in_ch.tune_coeff <= coef;
        in_ch.restart    <= rst;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        // accepted at this edge; the step always runs so the state tracks
        res = filter_sample(smp, coef, rst);
        if (typed)
        begin
            res.filtered    = want_filt;
            res.range_error = want_err;
        end
        due_outputs.push_back(res);
    endtask

    // stop offering and wait until every owed result has come back
    task automatic settle(input int tail);
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (due_outputs.size() != 0)
            @(posedge clk);
        repeat (tail) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        n_writes++;
        if (idx == REG_FILTER_MODE)
            mode_reg = val[MODE_W-1:0];
        else if (val <= DAMP_MAX)
            damp_reg = val;
    endtask

    // free-running clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // result side: random stall per beat, frozen while a long hold is on
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
            rx_left = 0;
        end
        else if (out_ch.ready)
        begin
            if (rx_hold)
                out_ch.ready <= 1'b0;
            else if (out_ch.valid)
            begin
                rx_left = rx_busy ? $urandom_range(0, MAX_WAIT) : 0;
                if (rx_left != 0)
                begin
                    out_ch.ready <= 1'b0;
                    rx_left = rx_left - 1;
                end
            end
        end
        else if (!rx_hold)
        begin
            if (rx_left == 0)
                out_ch.ready <= 1'b1;
            else
                rx_left = rx_left - 1;
        end
    end

    // long hold on the result side while samples keep coming, so the
    // filter backs up and has to stall its input
    initial
    begin
        rx_hold = 1'b0;
        wait (phase_no == 3);
        @(posedge clk);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_hold <= 1'b0;
    end

    // result checker: every accepted beat against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (due_outputs.size() == 0)
            begin
                $error("result beat with nothing owed: filtered %0d range_error %0b",
                       out_ch.filtered, out_ch.range_error);
                fails++;
            end
            else
            begin
                seen_want = due_outputs.pop_front();
                n_beats++;
                if (out_ch.filtered !== seen_want.filtered)
                begin
                    $error("filtered: expected %0d, got %0d",
                           seen_want.filtered, out_ch.filtered);
                    fails++;
                end
                if (out_ch.range_error !== seen_want.range_error)
                begin
                    $error("range_error: expected %0b, got %0b",
                           seen_want.range_error, out_ch.range_error);
                    fails++;
                end
                if (seen_want.range_error)
                    n_rejected++;
                else if (seen_want.filtered == OUT_MAX[OUT_W-1:0]
                         || seen_want.filtered == OUT_MIN[OUT_W-1:0])
                    n_clipped++;
            end
        end
    end

    // watchdog, several times the slowest legal run
    initial
    begin
        #8_000_000;
        $display("state_variable_filter_core regression: fail");
        $finish;
    end

    initial
    begin : stimulus
        int                         sent;
        int                         seq_len;
        bit                         drained;
        logic signed [SAMPLE_W-1:0] smp;
        logic [COEFF_W-1:0]         coef;
        logic                       rst;
        logic [DAMP_W-1:0]          damp;

        // everything known from time zero
        rst_n            = 1'b0;
        cfg_we           = 1'b0;
        cfg_index        = REG_FILTER_MODE;
        cfg_wdata        = '0;
        in_ch.valid      = 1'b0;
        in_ch.sample     = '0;
        in_ch.tune_coeff = '0;
        in_ch.restart    = 1'b0;
        out_ch.ready     = 1'b0;
        mode_reg         = MODE_LOW;
        damp_reg         = DAMP_RESET;
        low_acc          = 0;
        band_acc         = 0;
        tx_busy          = 1'b1;
        rx_busy          = 1'b1;
        drained          = 1'b0;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        foreach (directed_rows[i])
        begin
            case (directed_rows[i].kind)
                ROW_WRITE:
                begin
                    settle(4);
                    write_reg(directed_rows[i].reg_idx, directed_rows[i].reg_val);
                end
                ROW_BEAT:
                    send_sample(directed_rows[i].smp, directed_rows[i].coef,
                                directed_rows[i].rst, 1'b0, '0, 1'b0);
                default:
                    send_sample(directed_rows[i].smp, directed_rows[i].coef,
                                directed_rows[i].rst, 1'b1, directed_rows[i].want_filt,
                                directed_rows[i].want_err);
            endcase
        end

        // random phases, each under its own select and damping
        for (int ph = 0; ph < PHASES; ph++)
        begin
            settle(4);
            phase_no = ph;
            write_reg(REG_FILTER_MODE, CFG_DATA_W'($urandom_range(0, 3)));
            case ($urandom_range(0, 5))
                0:       damp = '0;
                1:       damp = DAMP_MAX;
                // above the limit, dropped by the filter
                2:       damp = DAMP_W'($urandom_range(int'(DAMP_MAX) + 1, (1 << DAMP_W) - 1));
                3:       damp = DAMP_W'($urandom_range(0, 4096));
                default: damp = DAMP_W'($urandom_range(0, int'(DAMP_MAX)));
            endcase
            write_reg(REG_DAMPING, damp);

            // phase 0 runs flat out; phase 3 keeps offering through the hold
            tx_busy = (ph != 0 && ph != 3 && ph != 6);
            rx_busy <= (ph != 0 && ph != 4);

            sent = 0;
            while (sent < PHASE_BEATS)
            begin
                // one run of samples through a mostly fixed tuning, mostly from a clean state
                seq_len = $urandom_range(4, 40);
                coef    = draw_coeff();
                for (int k = 0; k < seq_len && sent < PHASE_BEATS; k++)
                begin
                    if ($urandom_range(0, 19) == 0)
                        coef = draw_coeff();
                    rst = (k == 0) ? ($urandom_range(0, 4) != 0) : ($urandom_range(0, 39) == 0);
                    case ($urandom_range(0, 19))
                        // any bit pattern, mostly out of range
                        0:       smp = SAMPLE_W'($urandom());
                        1:       smp = $urandom_range(0, 1) ? SAMPLE_W'(UNITY) : SAMPLE_W'(-UNITY);
                        default: smp = SAMPLE_W'(int'($urandom_range(0, 2 * UNITY)) - UNITY);
                    endcase
                    send_sample(smp, coef, rst, 1'b0, '0, 1'b0);
                    sent++;
                end
                // mid-phase pause until the filter has handed back everything
                if (ph == 5 && !drained && sent >= PHASE_BEATS / 2)
                begin
                    settle(4);
                    drained = 1'b1;
                end
            end
        end

        settle(RESULT_LATENCY + 12);

        $display("covered %0d result beats: %0d rejected out of range, %0d clipped at the rail",
                 n_beats, n_rejected, n_clipped);
        $display("over %0d register writes and %0d setting phases, one long result-side hold",
                 n_writes, PHASES);
        if (fails == 0)
            $display("state_variable_filter_core regression: pass");
        else
            $display("state_variable_filter_core regression: fail");
        $finish;
    end

endmodule
